// File: sv/rsc_pkg.sv
// Package with the shared types, codes and widths of the row select compactor.
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int ROW_W    = 64;
    localparam int BLOCK_W  = 40;
    localparam int KEPT_W   = 41;
    localparam int ACC_W    = 8;
    localparam int FILL_W   = 3;
    localparam int BYTES_W  = 4;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;

    // Element formats
    localparam logic [1:0] FMT_ONE_BIT = 2'd0;
    localparam logic [1:0] FMT_TWO_BIT = 2'd1;
    localparam logic [1:0] FMT_WHOLE   = 2'd2;

    // Selection modes
    localparam logic MODE_BLOCK = 1'b0;
    localparam logic MODE_MASK  = 1'b1;

    // Register indexes, taken from paddr[5:3]
    localparam logic [2:0] REG_ELEM_FORMAT = 3'd0;
    localparam logic [2:0] REG_UNIT_BYTES  = 3'd1;
    localparam logic [2:0] REG_SELECT_MODE = 3'd2;
    localparam logic [2:0] REG_BLOCK_BEGIN = 3'd3;
    localparam logic [2:0] REG_BLOCK_END   = 3'd4;

    typedef struct packed {
        logic [1:0]         elem_format;
        logic [3:0]         unit_bytes;
        logic               select_mode;
        logic [BLOCK_W-1:0] block_begin;
        logic [BLOCK_W-1:0] block_end;
    } cfg_t;

endpackage

// File: sv/rsc_if.sv
// Stream interfaces for source rows and for compacted results.
`timescale 1ns / 1ps

interface rsc_row_if;
    logic                      valid;
    logic                      ready;
    logic [rsc_pkg::ROW_W-1:0] row_value;
    logic                      keep_mask;
    logic                      last_row;

    modport source (output valid, row_value, keep_mask, last_row, input ready);
    modport sink   (input valid, row_value, keep_mask, last_row, output ready);
endinterface

interface rsc_result_if;
    logic                        valid;
    logic                        ready;
    logic [rsc_pkg::ROW_W-1:0]   out_data;
    logic [rsc_pkg::BYTES_W-1:0] out_bytes;
    logic                        out_last;
    logic [rsc_pkg::KEPT_W-1:0]  kept_total;
    logic                        begin_error;

    modport source (output valid, out_data, out_bytes, out_last, kept_total, begin_error,
                    input ready);
    modport sink   (input valid, out_data, out_bytes, out_last, kept_total, begin_error,
                    output ready);
endinterface

// File: sv/rsc_apb_regs.sv
// APB configuration registers of the row select compactor.
`timescale 1ns / 1ps

module rsc_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output rsc_pkg::cfg_t                 cfg
);

    rsc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[5:3];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.elem_format <= rsc_pkg::FMT_ONE_BIT;
            cfg_reg.unit_bytes  <= 4'd1;
            cfg_reg.select_mode <= rsc_pkg::MODE_BLOCK;
            cfg_reg.block_begin <= '0;
            cfg_reg.block_end   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                rsc_pkg::REG_ELEM_FORMAT: cfg_reg.elem_format <= pwdata[1:0];
                rsc_pkg::REG_UNIT_BYTES:  cfg_reg.unit_bytes  <= pwdata[3:0];
                rsc_pkg::REG_SELECT_MODE: cfg_reg.select_mode <= pwdata[0];
                rsc_pkg::REG_BLOCK_BEGIN: cfg_reg.block_begin <= pwdata[rsc_pkg::BLOCK_W-1:0];
                rsc_pkg::REG_BLOCK_END:   cfg_reg.block_end   <= pwdata[rsc_pkg::BLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            rsc_pkg::REG_ELEM_FORMAT: prdata = rsc_pkg::PDATA_W'(cfg_reg.elem_format);
            rsc_pkg::REG_UNIT_BYTES:  prdata = rsc_pkg::PDATA_W'(cfg_reg.unit_bytes);
            rsc_pkg::REG_SELECT_MODE: prdata = rsc_pkg::PDATA_W'(cfg_reg.select_mode);
            rsc_pkg::REG_BLOCK_BEGIN: prdata = rsc_pkg::PDATA_W'(cfg_reg.block_begin);
            rsc_pkg::REG_BLOCK_END:   prdata = rsc_pkg::PDATA_W'(cfg_reg.block_end);
            default:                  prdata = '0;
        endcase
    end

endmodule

// File: sv/row_select_compactor_unit.sv
// Top level of the row select compactor: row register, keep test, packer and result register.
`timescale 1ns / 1ps

// One source row is taken per clock cycle while no result is held up at the output. A row
// transfer lands in an input register; from there the keep test, the bit packer and the
// record counters work on it in one pass and, when the row gives a result, load the result
// register once it is free or being taken. The sustained rate is one row per cycle for as
// long as the result side takes its transfers; the input register and the result register
// part the two sides, and rows that give no result move on even while a result waits.
// rows.ready depends combinationally on results.ready. Registers sit on a 64-bit APB port,
// register i at byte address 8*i; the user must write them only while no record is in
// flight, and the block itself does not enforce this.
module row_select_compactor_unit #(
    parameter int ROW_INDEX_BITS = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rsc_row_if.sink                     rows,
    rsc_result_if.source                results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0] paddr,
    input  logic [rsc_pkg::PDATA_W-1:0] pwdata,
    output logic [rsc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CMP_W = (ROW_INDEX_BITS > rsc_pkg::BLOCK_W) ? ROW_INDEX_BITS : rsc_pkg::BLOCK_W;

    rsc_pkg::cfg_t cfg;

    rsc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic                      in_valid_reg;
    logic [rsc_pkg::ROW_W-1:0] in_value_reg;
    logic                      in_mask_reg;
    logic                      in_last_reg;

    // Record state
    logic [ROW_INDEX_BITS-1:0]  row_cnt_reg, row_cnt_next;
    logic [rsc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [rsc_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [rsc_pkg::KEPT_W-1:0] kept_reg, kept_next;

    // Result register
    logic                        out_valid_reg;
    logic [rsc_pkg::ROW_W-1:0]   out_data_reg, out_data_next;
    logic [rsc_pkg::BYTES_W-1:0] out_bytes_reg, out_bytes_next;
    logic                        out_last_reg;
    logic [rsc_pkg::KEPT_W-1:0]  out_kept_reg;
    logic                        out_err_reg, out_err_next;

    logic                        keep;
    logic                        packed_fmt;
    logic                        have;
    logic                        emit;
    logic                        advance;
    logic                        out_free;
    logic [CMP_W-1:0]            idx_ext, begin_ext, end_ext;
    logic [1:0]                  new_bits;
    logic [3:0]                  shamt;
    logic [15:0]                 shifted;
    logic [rsc_pkg::ACC_W-1:0]   acc_or, acc_upd;
    logic [3:0]                  fill_inc, fill_upd;
    logic                        full;
    logic [3:0]                  unit_clamp;
    logic [rsc_pkg::ROW_W-1:0]   whole_data;

    assign idx_ext   = CMP_W'(row_cnt_reg);
    assign begin_ext = CMP_W'(cfg.block_begin);
    assign end_ext   = CMP_W'(cfg.block_end);

    assign keep = (cfg.select_mode == rsc_pkg::MODE_MASK) ? in_mask_reg
                : ((idx_ext >= begin_ext) && (idx_ext <= end_ext));

    assign kept_next = (keep && (kept_reg != {rsc_pkg::KEPT_W{1'b1}})) ? kept_reg + 1'b1 : kept_reg;

    assign packed_fmt = (cfg.elem_format == rsc_pkg::FMT_ONE_BIT)
                     || (cfg.elem_format == rsc_pkg::FMT_TWO_BIT);

    // Packing: two-bit rows shift by twice the fill, bits past bit 7 drop off.
    assign new_bits = (cfg.elem_format == rsc_pkg::FMT_ONE_BIT) ? {1'b0, in_value_reg[0]}
                                                                : in_value_reg[1:0];
    assign shamt    = (cfg.elem_format == rsc_pkg::FMT_ONE_BIT) ? {1'b0, fill_reg}
                                                                : {fill_reg, 1'b0};
    assign shifted  = {14'd0, new_bits} << shamt;
    assign acc_or   = acc_reg | shifted[rsc_pkg::ACC_W-1:0];
    assign fill_inc = {1'b0, fill_reg} + 4'd1;
    assign full     = (cfg.elem_format == rsc_pkg::FMT_ONE_BIT) ? fill_inc[3] : (fill_inc >= 4'd4);

    assign unit_clamp = (cfg.unit_bytes == 4'd0) ? 4'd1
                      : (cfg.unit_bytes > 4'd8) ? 4'd8 : cfg.unit_bytes;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            whole_data[8*b +: 8] = (4'(b) < unit_clamp) ? in_value_reg[8*b +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        have           = 1'b0;
        out_data_next  = '0;
        out_bytes_next = '0;
        acc_upd        = acc_reg;
        fill_upd       = {1'b0, fill_reg};
        if (packed_fmt)
        begin
            if (keep)
            begin
                if (full)
                begin
                    have           = 1'b1;
                    out_data_next  = rsc_pkg::ROW_W'(acc_or);
                    out_bytes_next = 4'd1;
                    acc_upd        = '0;
                    fill_upd       = 4'd0;
                end
                else
                begin
                    acc_upd  = acc_or;
                    fill_upd = fill_inc;
                end
            end
            // The closing row flushes a partly filled byte.
            if (in_last_reg && !have && (fill_upd != 4'd0))
            begin
                have           = 1'b1;
                out_data_next  = rsc_pkg::ROW_W'(acc_upd);
                out_bytes_next = 4'd1;
            end
        end
        else if (keep)
        begin
            have           = 1'b1;
            out_data_next  = whole_data;
            out_bytes_next = unit_clamp;
        end
    end

    assign emit         = have || in_last_reg;
    assign out_err_next = in_last_reg && (cfg.select_mode == rsc_pkg::MODE_BLOCK)
                       && (begin_ext > idx_ext);

    assign out_free = !out_valid_reg || results.ready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign rows.ready = !in_valid_reg || advance;

    assign row_cnt_next = row_cnt_reg + 1'b1;
    assign acc_next     = acc_upd;
    assign fill_next    = fill_upd[rsc_pkg::FILL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rows.ready)
        begin
            in_valid_reg <= rows.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rows.valid && rows.ready)
        begin
            in_value_reg <= rows.row_value;
            in_mask_reg  <= rows.keep_mask;
            in_last_reg  <= rows.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            acc_reg     <= '0;
            fill_reg    <= '0;
            kept_reg    <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                row_cnt_reg <= '0;
                acc_reg     <= '0;
                fill_reg    <= '0;
                kept_reg    <= '0;
            end
            else
            begin
                row_cnt_reg <= row_cnt_next;
                acc_reg     <= acc_next;
                fill_reg    <= fill_next;
                kept_reg    <= kept_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg  <= out_data_next;
            out_bytes_reg <= out_bytes_next;
            out_last_reg  <= in_last_reg;
            out_kept_reg  <= kept_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_data    = out_data_reg;
    assign results.out_bytes   = out_bytes_reg;
    assign results.out_last    = out_last_reg;
    assign results.kept_total  = out_kept_reg;
    assign results.begin_error = out_err_reg;

    // A closing row leaves the record state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (row_cnt_reg == '0 && kept_reg == '0 && fill_reg == '0
                                      && acc_reg == '0))
        else $error("record state not cleared after closing row");

    // Only the closing result may be empty.
    a_empty_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.out_last) |-> (results.out_bytes != 4'd0))
        else $error("empty result before end of record");

    // The begin flag is raised only on the closing result.
    a_err_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.begin_error) |-> results.out_last)
        else $error("begin flag on a result that does not close the record");

    // Within a record the kept count never falls.
    a_kept_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_last_reg) |=> (kept_reg >= $past(kept_reg)))
        else $error("kept count fell within a record");

endmodule

// File: tb/rsc_result_checker.sv
// Checker that predicts the compacted results from observed row transfers and compares them.
`timescale 1ns / 1ps

module rsc_result_checker
    import rsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rsc_row_if                 rows,
    rsc_result_if              results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               drain_done,
    output int                 outstanding,
    output int                 fail_count
);

    typedef struct packed {
        logic [ROW_W-1:0]   data;
        logic [BYTES_W-1:0] nbytes;
        logic               last;
        logic [KEPT_W-1:0]  kept;
        logic               begin_error;
    } compacted_t;

    cfg_t               regs;
    logic [BLOCK_W-1:0] row_idx;
    logic [ACC_W-1:0]   acc;
    logic [FILL_W:0]    fill;
    logic [KEPT_W-1:0]  kept_cnt;
    compacted_t         pending_results[$];
    compacted_t         predicted;
    compacted_t         observed;
    compacted_t         wanted;
    logic               leftovers_checked;

    task automatic report(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Advances the record state by one row and returns 1 when the row yields a result.
    function automatic logic compact_row(input logic [ROW_W-1:0] value, input logic mask_bit,
                                         input logic last, output compacted_t res);
        logic [BLOCK_W-1:0] idx;
        logic               keep;
        logic               have;
        logic [15:0]        shifted;
        logic [3:0]         u;
        idx  = row_idx;
        have = 1'b0;
        res  = '0;
        if (regs.select_mode == MODE_MASK)
            keep = mask_bit;
        else
            keep = (idx >= regs.block_begin) && (idx <= regs.block_end);
        if (keep && kept_cnt != '1)
            kept_cnt = kept_cnt + 1'b1;
        if (regs.elem_format == FMT_ONE_BIT || regs.elem_format == FMT_TWO_BIT)
        begin
            if (keep)
            begin
                if (regs.elem_format == FMT_ONE_BIT)
                    shifted = 16'(value[0]) << fill[2:0];
                else
                    shifted = 16'(value[1:0]) << {fill[2:0], 1'b0};
                // Bits pushed past the top of the byte are dropped.
                acc  = acc | shifted[7:0];
                fill = fill + 1'b1;
                if ((regs.elem_format == FMT_ONE_BIT && fill >= 4'd8) ||
                    (regs.elem_format == FMT_TWO_BIT && fill >= 4'd4))
                begin
                    have       = 1'b1;
                    res.data   = ROW_W'(acc);
                    res.nbytes = 4'd1;
                    acc        = '0;
                    fill       = '0;
                end
            end
            if (last && !have && fill != 0)
            begin
                have       = 1'b1;
                res.data   = ROW_W'(acc);
                res.nbytes = 4'd1;
            end
            fill = {1'b0, fill[2:0]};
        end
        else if (keep)
        begin
            u = regs.unit_bytes;
            if (u == 4'd0)
                u = 4'd1;
            if (u > 4'd8)
                u = 4'd8;
            have       = 1'b1;
            res.nbytes = u;
            res.data   = (u == 4'd8) ? value : value & ((64'd1 << {u, 3'b000}) - 64'd1);
        end
        row_idx         = idx + 1'b1;
        res.last        = last;
        res.kept        = kept_cnt;
        res.begin_error = last && regs.select_mode == MODE_BLOCK && regs.block_begin > idx;
        if (last)
        begin
            row_idx  = '0;
            acc      = '0;
            fill     = '0;
            kept_cnt = '0;
        end
        return have || last;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.elem_format  = FMT_ONE_BIT;
            regs.unit_bytes   = 4'd1;
            regs.select_mode  = MODE_BLOCK;
            regs.block_begin  = '0;
            regs.block_end    = '0;
            row_idx           = '0;
            acc               = '0;
            fill              = '0;
            kept_cnt          = '0;
            leftovers_checked = 1'b0;
            fail_count        = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:3])
                    REG_ELEM_FORMAT: regs.elem_format = pwdata[1:0];
                    REG_UNIT_BYTES:  regs.unit_bytes  = pwdata[3:0];
                    REG_SELECT_MODE: regs.select_mode = pwdata[0];
                    REG_BLOCK_BEGIN: regs.block_begin = pwdata[BLOCK_W-1:0];
                    REG_BLOCK_END:   regs.block_end   = pwdata[BLOCK_W-1:0];
                    default: ;
                endcase
            end

            // Results are compared before this edge's row is predicted: a row's result
            // can never leave in the same cycle as its own transfer.
            if (results.valid && results.ready)
            begin
                observed.data        = results.out_data;
                observed.nbytes      = results.out_bytes;
                observed.last        = results.out_last;
                observed.kept        = results.kept_total;
                observed.begin_error = results.begin_error;
                if (pending_results.size() == 0)
                    report($sformatf("unexpected result data %h bytes %0d last %0b",
                                     observed.data, observed.nbytes, observed.last));
                else
                begin
                    wanted = pending_results.pop_front();
                    if (observed.data !== wanted.data)
                        report($sformatf("out_data %h, predicted %h",
                                         observed.data, wanted.data));
                    if (observed.nbytes !== wanted.nbytes)
                        report($sformatf("out_bytes %0d, predicted %0d",
                                         observed.nbytes, wanted.nbytes));
                    if (observed.last !== wanted.last)
                        report($sformatf("out_last %b, predicted %b",
                                         observed.last, wanted.last));
                    if (observed.kept !== wanted.kept)
                        report($sformatf("kept_total %0d, predicted %0d",
                                         observed.kept, wanted.kept));
                    if (observed.begin_error !== wanted.begin_error)
                        report($sformatf("begin_error %b, predicted %b",
                                         observed.begin_error, wanted.begin_error));
                end
            end

            if (rows.valid && rows.ready)
            begin
                if (compact_row(rows.row_value, rows.keep_mask, rows.last_row, predicted))
                    pending_results.push_back(predicted);
            end

            if (drain_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (pending_results.size() != 0)
                    report($sformatf("%0d predicted results never arrived",
                                     pending_results.size()));
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: tb/tb_row_select_compactor_unit.sv
// Top of the row select compactor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_row_select_compactor_unit;
    import rsc_pkg::*;

    localparam int         CYCLE_LIMIT = 300000;
    localparam int         RANDOM_ROWS = 650;
    localparam int         CALM_ROWS   = 120;
    // The format code that the register allows beyond the three named ones.
    localparam logic [1:0] FMT_THREE   = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               drain_done;
    int                 outstanding;
    int                 fail_count;
    int                 rows_sent;
    int                 send_gap_pct;
    int                 stall_pct;
    int                 cycle_count;
    bit                 calm;

    rsc_row_if    rows_ch();
    rsc_result_if results_ch();

    row_select_compactor_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (rows_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rsc_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .rows        (rows_ch),
        .results     (results_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .drain_done  (drain_done),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_row_select_compactor_unit: FAIL");
        $finish;
    end

    // Result side: random stalls in bursts, none once the run has gone calm.
    initial
    begin
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                results_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
        end
    end

    task automatic send_row(input logic [ROW_W-1:0] value, input logic mask_bit,
                            input logic last);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            rows_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        rows_ch.valid     <= 1'b1;
        rows_ch.row_value <= value;
        rows_ch.keep_mask <= mask_bit;
        rows_ch.last_row  <= last;
        @(posedge clk);
        while (!rows_ch.ready)
            @(posedge clk);
    endtask

    // Holds the row side until every predicted result has been taken, then lets any
    // row that yields no result clear the pipeline.
    task automatic quiesce();
        rows_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [BLOCK_W-1:0] window_edge();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return BLOCK_W'({$urandom, $urandom});
            default: return BLOCK_W'($urandom_range(0, 40));
        endcase
    endfunction

    initial
    begin
        int len;
        int density;
        rows_ch.valid     <= 1'b0;
        rows_ch.row_value <= '0;
        rows_ch.keep_mask <= 1'b0;
        rows_ch.last_row  <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        drain_done        <= 1'b0;
        rst_n             <= 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        calm         = 1'b0;
        rows_sent    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the window holds row 0 only, so the last row flushes one bit.
        send_row('1, 1'b0, 1'b0);
        send_row('0, 1'b1, 1'b1);

        // A byte that fills up on the last row itself.
        quiesce();
        write_reg(REG_SELECT_MODE, PDATA_W'(MODE_MASK));
        for (int i = 0; i < 8; i++)
            send_row((i % 2) ? '1 : '0, 1'b1, i == 7);

        // Format change part-way through a record: five one-bit rows held, then a
        // two-bit row that overflows the byte.
        quiesce();
        for (int i = 0; i < 5; i++)
            send_row('1, 1'b1, 1'b0);
        quiesce();
        write_reg(REG_ELEM_FORMAT, PDATA_W'(FMT_TWO_BIT));
        send_row(64'd3, 1'b1, 1'b1);

        // Format three with unit sizes below and above the legal range.
        quiesce();
        write_reg(REG_ELEM_FORMAT, PDATA_W'(FMT_THREE));
        write_reg(REG_UNIT_BYTES, 64'd0);
        send_row('1, 1'b1, 1'b0);
        quiesce();
        write_reg(REG_UNIT_BYTES, 64'd15);
        send_row('1, 1'b1, 1'b1);

        // Window starting past the data: empty flush with the begin error raised.
        quiesce();
        write_reg(REG_ELEM_FORMAT, PDATA_W'(FMT_WHOLE));
        write_reg(REG_UNIT_BYTES, 64'd8);
        write_reg(REG_SELECT_MODE, PDATA_W'(MODE_BLOCK));
        write_reg(REG_BLOCK_BEGIN, PDATA_W'({BLOCK_W{1'b1}}));
        write_reg(REG_BLOCK_END, PDATA_W'({BLOCK_W{1'b1}}));
        send_row(64'h0123_4567_89ab_cdef, 1'b1, 1'b0);
        send_row(64'hfedc_ba98_7654_3210, 1'b1, 1'b1);

        // Empty window: end below begin keeps nothing.
        quiesce();
        write_reg(REG_BLOCK_BEGIN, 64'd1);
        write_reg(REG_BLOCK_END, 64'd0);
        send_row('1, 1'b1, 1'b0);
        send_row('1, 1'b1, 1'b1);

        while (rows_sent < RANDOM_ROWS)
        begin
            quiesce();
            if (rows_sent >= RANDOM_ROWS - CALM_ROWS)
                calm = 1'b1;
            send_gap_pct = calm ? 0 : $urandom_range(0, 2) * 15;
            stall_pct    = calm ? 0 : $urandom_range(0, 2) * 6;
            write_reg(REG_ELEM_FORMAT, PDATA_W'($urandom_range(FMT_ONE_BIT, FMT_THREE)));
            write_reg(REG_UNIT_BYTES, PDATA_W'($urandom_range(0, 15)));
            write_reg(REG_SELECT_MODE, PDATA_W'($urandom_range(MODE_BLOCK, MODE_MASK)));
            write_reg(REG_BLOCK_BEGIN, PDATA_W'(window_edge()));
            write_reg(REG_BLOCK_END, PDATA_W'(window_edge()));
            repeat ($urandom_range(1, 4))
            begin
                len     = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 24);
                density = $urandom_range(0, 100);
                for (int i = 0; i < len; i++)
                    send_row({$urandom, $urandom}, $urandom_range(0, 99) < density,
                             i == len - 1);
                rows_sent += len;
            end
        end

        quiesce();
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("tb_row_select_compactor_unit: PASS");
        else
            $display("tb_row_select_compactor_unit: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/rsc_pkg.sv
sv/rsc_if.sv
sv/rsc_apb_regs.sv
sv/row_select_compactor_unit.sv
tb/rsc_result_checker.sv
tb/tb_row_select_compactor_unit.sv
